FILE: src/prt_pkg.sv
`timescale 1ns / 1ps

package prt_pkg;

    // Table size default, handed to the top level
    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int KEY_W         = 64;
    localparam int IP_W          = 32;
    localparam int PORT_W        = 16;
    localparam int STATUS_W      = 4;
    localparam int OTHER_COUNT_W = 6;
    localparam int CMD_W         = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRINT      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MALFORMED  = 2'd3;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_REG_OK     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_DUP        = 4'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 4'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_UNREG_OK   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_UNREG_MISS = 4'd6;
    localparam logic [STATUS_W-1:0] ST_ENTRY      = 4'd7;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 4'd8;

    // One stored peer
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   ip;
        logic [KEY_W-1:0]  key;
    } entry_t;

    // One request as taken from the input channel
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        entry_t           entry;
        logic             addr_ok;
        logic             key_ok;
    } req_t;

    // One response item
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [OTHER_COUNT_W-1:0] other_count;
        logic [IP_W-1:0]          ip;
        logic [PORT_W-1:0]        port;
        logic [KEY_W-1:0]         key;
        logic                     last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_RESP,
        S_LIST
    } state_t;

endpackage

FILE: src/peer_registry_table.sv
`timescale 1ns / 1ps

// Peer registry table.
// Input channel s_*: one request per transaction (register, unregister,
// print or malformed), with key, address and port in s_tdata and the
// command and presence flags in s_tuser. Output channel m_*: one or more
// response transactions per request, m_tlast marking the final one.
// Requests are handled one at a time; s_tready is high only while idle.
// Register and unregister scan all slots with the single key comparator,
// one slot per cycle, before their first response leaves. A successful
// register or a print then walks the slots again, one slot per cycle
// while the output is free, giving at most one listed entry per cycle.
// A malformed request or a print of an empty table goes straight to its
// response without a scan.
// Reset clears all valid marks, the peer count and both channels; the
// slot contents are left as they are and are never used before written.
// When the receiver holds m_tready low the response stays in the output
// register and the slot walk pauses; nothing is dropped.
module peer_registry_table #(
    parameter int TABLE_ENTRIES = prt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] peer_key, [95:64] peer_ip, [111:96] peer_port
    input  logic [111:0] s_tdata,
    // [1:0] command, [2] addr_present, [3] key_present
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] status, [9:4] other_count, [41:10] entry_ip, [57:42] entry_port,
    // [121:58] entry_key, [127:122] zero
    output logic [127:0] m_tdata,
    output logic         m_tlast
);
    import prt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    req_t             req;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_idx;
    entry_t           mem_wr_entry;
    logic [IDX_W-1:0] mem_rd_idx;
    entry_t           mem_rd_entry;
    logic             out_free;
    logic             res_load;
    res_t             res;

    logic             m_tvalid_reg, m_tvalid_next;
    res_t             res_reg;

    // Unpack the request
    assign req.cmd          = s_tuser[1:0];
    assign req.addr_ok      = s_tuser[2];
    assign req.key_ok       = s_tuser[3];
    assign req.entry.key    = s_tdata[63:0];
    assign req.entry.ip     = s_tdata[95:64];
    assign req.entry.port   = s_tdata[111:96];

    prt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req          (req),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_idx   (mem_wr_idx),
        .mem_wr_entry (mem_wr_entry),
        .mem_rd_idx   (mem_rd_idx),
        .mem_rd_entry (mem_rd_entry),
        .out_free     (out_free),
        .res_load     (res_load),
        .res          (res)
    );

    prt_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_mem (
        .aclk     (aclk),
        .wr_en    (mem_wr_en),
        .wr_idx   (mem_wr_idx),
        .wr_entry (mem_wr_entry),
        .rd_idx   (mem_rd_idx),
        .rd_entry (mem_rd_entry)
    );

    // Output register
    assign out_free      = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = res_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {6'd0, res_reg.key, res_reg.port, res_reg.ip,
                       res_reg.other_count, res_reg.status};

endmodule

FILE: src/prt_mem.sv
`timescale 1ns / 1ps

module prt_mem #(
    parameter int TABLE_ENTRIES = prt_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  prt_pkg::entry_t      wr_entry,
    input  logic [IDX_W-1:0]     rd_idx,
    output prt_pkg::entry_t      rd_entry
);
    import prt_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_entry_reg;

    // Single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_idx];
    end

    assign rd_entry = rd_entry_reg;

endmodule

FILE: src/prt_ctrl.sv
`timescale 1ns / 1ps

module prt_ctrl #(
    parameter int TABLE_ENTRIES = prt_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request side
    input  logic                 req_valid,
    output logic                 req_ready,
    input  prt_pkg::req_t        req,
    // table memory
    output logic                 mem_wr_en,
    output logic [IDX_W-1:0]     mem_wr_idx,
    output prt_pkg::entry_t      mem_wr_entry,
    output logic [IDX_W-1:0]     mem_rd_idx,
    input  prt_pkg::entry_t      mem_rd_entry,
    // response side
    input  logic                 out_free,
    output logic                 res_load,
    output prt_pkg::res_t        res
);
    import prt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t                    state_reg, state_next;
    req_t                      req_reg, req_next;
    logic [TABLE_ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          remain_reg, remain_next;
    logic [IDX_W-1:0]          scan_idx_reg, scan_idx_next;
    logic                      free_found_reg, free_found_next;
    logic [IDX_W-1:0]          free_idx_reg, free_idx_next;
    logic                      hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic                      excl_reg, excl_next;
    logic [STATUS_W-1:0]       resp_status_reg, resp_status_next;
    logic [OTHER_COUNT_W-1:0]  resp_count_reg, resp_count_next;
    logic                      resp_last_reg, resp_last_next;

    logic                      accept;
    logic                      scan_end;
    logic                      slot_valid;
    logic                      key_match;
    logic                      list_slot;
    logic                      list_last;
    logic                      reg_bad;

    assign accept     = req_valid && req_ready;
    assign scan_end   = (scan_idx_reg == LAST_IDX);
    assign slot_valid = valid_reg[scan_idx_reg];
    // the shared compare unit: one slot key against the request key per cycle
    assign key_match  = slot_valid && (mem_rd_entry.key == req_reg.entry.key);
    assign list_slot  = slot_valid && !(excl_reg && (scan_idx_reg == free_idx_reg));
    assign list_last  = (remain_reg == CNT_W'(1));
    assign reg_bad    = !req_reg.addr_ok || !req_reg.key_ok
                        || (req_reg.entry.port == '0);

    // Read address follows the next scan index, so read data lines up with it
    assign mem_rd_idx = scan_idx_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (req.cmd)
                        CMD_REGISTER, CMD_UNREGISTER: state_next = S_FIND;
                        CMD_PRINT:     state_next = (count_reg == '0) ? S_RESP : S_LIST;
                        CMD_MALFORMED: state_next = S_RESP;
                    endcase
                end
            end
            S_FIND: begin
                if (scan_end) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = resp_last_reg ? S_IDLE : S_LIST;
                end
            end
            S_LIST: begin
                if (list_slot && out_free && list_last) begin
                    state_next = S_IDLE;
                end else if (scan_end && !(list_slot && !out_free)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        req_next         = req_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        scan_idx_next    = scan_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        excl_next        = excl_reg;
        resp_status_next = resp_status_reg;
        resp_count_next  = resp_count_reg;
        resp_last_next   = resp_last_reg;
        req_ready        = 1'b0;
        mem_wr_en        = 1'b0;
        mem_wr_idx       = free_idx_reg;
        mem_wr_entry     = req_reg.entry;
        res_load         = 1'b0;
        res              = '0;

        unique case (state_reg)
            S_IDLE: begin
                req_ready       = 1'b1;
                scan_idx_next   = '0;
                free_found_next = 1'b0;
                hit_found_next  = 1'b0;
                resp_count_next = '0;
                resp_last_next  = 1'b1;
                excl_next       = 1'b0;
                remain_next     = count_reg;
                if (accept) begin
                    req_next = req;
                    if (req.cmd == CMD_PRINT) begin
                        resp_status_next = ST_EMPTY;
                    end else begin
                        resp_status_next = ST_ERROR;
                    end
                end
            end

            // one slot per cycle: first free slot and first key match
            S_FIND: begin
                if (!slot_valid && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_idx_reg;
                end
                if (key_match && !hit_found_reg) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = scan_idx_reg;
                end
                if (!scan_end) begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end

            // settle the answer and commit the table change
            S_DECIDE: begin
                scan_idx_next  = '0;
                resp_last_next = 1'b1;
                if (req_reg.cmd == CMD_REGISTER) begin
                    if (!free_found_reg) begin
                        resp_status_next = ST_FULL;
                    end else if (req_reg.key_ok && hit_found_reg) begin
                        resp_status_next = ST_DUP;
                    end else if (reg_bad) begin
                        resp_status_next = ST_INVALID;
                    end else begin
                        mem_wr_en                 = 1'b1;
                        valid_next[free_idx_reg]  = 1'b1;
                        count_next                = count_reg + CNT_W'(1);
                        resp_status_next          = ST_REG_OK;
                        resp_count_next           = OTHER_COUNT_W'(count_reg);
                        resp_last_next            = (count_reg == '0);
                        remain_next               = count_reg;
                        excl_next                 = 1'b1;
                    end
                end else begin
                    if (req_reg.key_ok && hit_found_reg) begin
                        valid_next[hit_idx_reg] = 1'b0;
                        count_next              = count_reg - CNT_W'(1);
                        resp_status_next        = ST_UNREG_OK;
                    end else begin
                        resp_status_next = ST_UNREG_MISS;
                    end
                end
            end

            S_RESP: begin
                scan_idx_next   = '0;
                res.status      = resp_status_reg;
                res.other_count = resp_count_reg;
                res.last        = resp_last_reg;
                res_load        = out_free;
            end

            // walk the slots, one listed entry per cycle when the output is free
            S_LIST: begin
                res.status = ST_ENTRY;
                res.ip     = mem_rd_entry.ip;
                res.port   = mem_rd_entry.port;
                res.key    = mem_rd_entry.key;
                res.last   = list_last;
                if (list_slot) begin
                    if (out_free) begin
                        res_load    = 1'b1;
                        remain_next = remain_reg - CNT_W'(1);
                        if (!scan_end) begin
                            scan_idx_next = scan_idx_reg + IDX_W'(1);
                        end
                    end
                end else if (!scan_end) begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end

            default: begin
                scan_idx_next = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        req_reg         <= req_next;
        remain_reg      <= remain_next;
        scan_idx_reg    <= scan_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        excl_reg        <= excl_next;
        resp_status_reg <= resp_status_next;
        resp_count_reg  <= resp_count_next;
        resp_last_reg   <= resp_last_next;
    end

endmodule
